[rtl/hvd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and cost arithmetic for the HMM Viterbi decoder.
// Used by hvd_acs_cell and hmm_viterbi_decoder_core; depends on nothing else.

package hvd_pkg;

   localparam int unsigned NUM_STATES  = 8;
   localparam int unsigned STATE_W     = 3;
   localparam int unsigned NUM_SYMBOLS = 16;
   localparam int unsigned SYM_W       = 4;
   localparam int unsigned MAX_LENGTH  = 64;
   localparam int unsigned POS_W       = 6;
   localparam int unsigned LEN_W       = 7;
   localparam int unsigned COST_W      = 16;

   localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD_TRANS = 2'd0,
      OP_LOAD_EMIS  = 2'd1,
      OP_LOAD_INIT  = 2'd2,
      OP_OBSERVE    = 2'd3
   } op_type;

   typedef logic [NUM_STATES-1:0][STATE_W-1:0] bp_row_type;

   // Table writes broadcast to every cell; each cell keeps its own slice.
   typedef struct packed {
      logic               trans_we;
      logic               emis_we;
      logic               init_we;
      logic [STATE_W-1:0] row;
      logic [SYM_W-1:0]   column;
      logic [COST_W-1:0]  cost;
   } cell_load_type;

   typedef struct packed {
      logic              load_e;
      logic [SYM_W-1:0]  symbol;
      logic              init_en;
      logic              acs_en;
      logic              norm_en;
      logic              clear_en;
      logic [COST_W-1:0] min;
   } cell_ctl_type;

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == COST_INF || b == COST_INF || s >= {1'b0, COST_INF}) begin
         return COST_INF;
      end
      return s[COST_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/hmm_viterbi_decoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Top level of the HMM Viterbi decoder: a ring of ACS cells, backpointer and path
// memories, and the sequencer. Depends on hvd_pkg and hvd_acs_cell.
//
//   Channel   Ports                          Handshake
//   request   req_operation .. req_last      taken when start is high and busy low
//   response  rsp_path_state .. rsp_overflow one cycle each, marked by rsp_strobe
//
// Table loads leave busy low. An observe item rotates the metrics past all 8 cells
// (on the first symbol of a sequence it loads the initial costs instead), then runs a
// min pass and a normalize pass. A last item then starts the traceback, steps back
// through each stored step after the first, emits the path entries and finishes.
// Reset is synchronous and clears the sequencer, the step count and the metrics.
// Results cannot be stalled.

module hmm_viterbi_decoder_core import hvd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_operation,
   input  wire logic [STATE_W-1:0] req_row,
   input  wire logic [SYM_W-1:0]   req_column,
   input  wire logic [COST_W-1:0]  req_cost,
   input  wire logic [SYM_W-1:0]   req_symbol,
   input  wire logic               req_last,
   output logic                    rsp_strobe,
   output logic [STATE_W-1:0]      rsp_path_state,
   output logic [POS_W-1:0]        rsp_position,
   output logic                    rsp_path_end,
   output logic                    rsp_overflow
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ACS,
      ST_MIN,
      ST_NORM,
      ST_TB_START,
      ST_TB_READ,
      ST_TB_STEP,
      ST_EMIT_READ,
      ST_EMIT_OUT,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [LEN_W-1:0]   ts_ff;
   logic               drop_ff;
   logic               last_ff;
   logic [STATE_W-1:0] k_ff;
   logic [COST_W-1:0]  mn_ff;
   logic [STATE_W-1:0] cur_ff;
   logic [POS_W-1:0]   t_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               rsp_strobe_ff;
   logic [STATE_W-1:0] rsp_path_state_ff;
   logic [POS_W-1:0]   rsp_position_ff;
   logic               rsp_path_end_ff;
   logic               rsp_overflow_ff;

   bp_row_type         bp_mem [MAX_LENGTH];
   bp_row_type         bp_q;
   logic [STATE_W-1:0] path_mem [MAX_LENGTH];
   logic [STATE_W-1:0] path_q;

   cell_load_type      load;
   cell_ctl_type       ctl;
   logic [COST_W-1:0]  metric [NUM_STATES];
   logic [STATE_W-1:0] src [NUM_STATES];
   logic [COST_W-1:0]  best [NUM_STATES];
   bp_row_type         arg_row;

   logic               accept;
   logic               obs_go;
   logic [COST_W-1:0]  min_in;
   logic [STATE_W-1:0] final_in;
   logic [COST_W-1:0]  final_cost;
   logic               path_we;
   logic [POS_W-1:0]   path_wa;
   logic [STATE_W-1:0] path_wd;
   logic [POS_W-1:0]   last_pos;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign obs_go   = accept && req_operation == OP_OBSERVE && ts_ff != LEN_W'(MAX_LENGTH);
   assign last_pos = POS_W'(ts_ff - 1'b1);

   always_comb begin
      load.trans_we = accept && req_operation == OP_LOAD_TRANS
                      && req_column < SYM_W'(NUM_STATES);
      load.emis_we  = accept && req_operation == OP_LOAD_EMIS;
      load.init_we  = accept && req_operation == OP_LOAD_INIT;
      load.row      = req_row;
      load.column   = req_column;
      load.cost     = req_cost;
      ctl.load_e    = obs_go;
      ctl.symbol    = req_symbol;
      ctl.init_en   = (state_ff == ST_INIT);
      ctl.acs_en    = (state_ff == ST_ACS);
      ctl.norm_en   = (state_ff == ST_NORM);
      ctl.clear_en  = (state_ff == ST_FINISH);
      ctl.min       = mn_ff;
   end

   // Each cell takes its neighbor's metric, so cell j sees source j-k at rotation k.
   for (genvar j = 0; j < NUM_STATES; j++) begin : g_cell
      hvd_acs_cell #(
         .CELL_INDEX(j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .ctl        (ctl),
         .metric_in  (metric[(j + NUM_STATES - 1) % NUM_STATES]),
         .src_in     (src[(j + NUM_STATES - 1) % NUM_STATES]),
         .metric_out (metric[j]),
         .src_out    (src[j]),
         .best_out   (best[j]),
         .arg_out    (arg_row[j])
      );
   end

   always_comb begin
      min_in     = COST_INF;
      final_cost = COST_INF;
      final_in   = '0;
      for (int i = 0; i < NUM_STATES; i++) begin
         if (best[i] < min_in) begin
            min_in = best[i];
         end
         if (metric[i] < final_cost) begin
            final_cost = metric[i];
            final_in   = STATE_W'(i);
         end
      end
   end

   always_comb begin
      path_we = 1'b0;
      path_wa = last_pos;
      path_wd = final_in;
      if (state_ff == ST_TB_START) begin
         path_we = 1'b1;
      end else if (state_ff == ST_TB_STEP) begin
         path_we = 1'b1;
         path_wa = t_ff - 1'b1;
         path_wd = bp_q[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_NORM) begin
         bp_mem[ts_ff[POS_W-1:0]] <= arg_row;
      end
      bp_q <= bp_mem[t_ff];
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_wa] <= path_wd;
      end
      path_q <= path_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ts_ff         <= '0;
         drop_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_operation == OP_OBSERVE) begin
                  last_ff <= req_last;
                  k_ff    <= '0;
                  if (!obs_go) begin
                     drop_ff  <= 1'b1;
                     state_ff <= req_last ? ST_TB_START : ST_IDLE;
                  end else begin
                     state_ff <= (ts_ff == '0) ? ST_INIT : ST_ACS;
                  end
               end
            end
            ST_INIT: begin
               state_ff <= ST_MIN;
            end
            ST_ACS: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == STATE_W'(NUM_STATES - 1)) begin
                  state_ff <= ST_MIN;
               end
            end
            ST_MIN: begin
               mn_ff    <= min_in;
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               ts_ff    <= ts_ff + 1'b1;
               state_ff <= last_ff ? ST_TB_START : ST_IDLE;
            end
            ST_TB_START: begin
               cur_ff   <= final_in;
               t_ff     <= last_pos;
               pos_ff   <= '0;
               state_ff <= (last_pos == '0) ? ST_EMIT_READ : ST_TB_READ;
            end
            ST_TB_READ: begin
               state_ff <= ST_TB_STEP;
            end
            ST_TB_STEP: begin
               cur_ff   <= bp_q[cur_ff];
               t_ff     <= t_ff - 1'b1;
               state_ff <= (t_ff == POS_W'(1)) ? ST_EMIT_READ : ST_TB_READ;
            end
            ST_EMIT_READ: begin
               state_ff <= ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
               rsp_strobe_ff     <= 1'b1;
               rsp_path_state_ff <= path_q;
               rsp_position_ff   <= pos_ff;
               rsp_path_end_ff   <= (pos_ff == last_pos);
               rsp_overflow_ff   <= drop_ff;
               pos_ff            <= pos_ff + 1'b1;
               state_ff          <= (pos_ff == last_pos) ? ST_FINISH : ST_EMIT_READ;
            end
            ST_FINISH: begin
               ts_ff    <= '0;
               drop_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_path_state = rsp_path_state_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_path_end   = rsp_path_end_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("path item shown while the core is idle");

   a_end_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_path_end |=> !rsp_strobe)
      else $error("path item after the final entry");

   a_next_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_path_end |=> !rsp_strobe ##1
      (rsp_strobe && rsp_position == POS_W'($past(rsp_position, 2) + 1'b1)))
      else $error("path positions not consecutive");

endmodule

`default_nettype wire

[rtl/hvd_acs_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// One add-compare-select cell of the decoder ring, owning one destination state.
// Depends on hvd_pkg for types, constants and saturating addition.

module hvd_acs_cell import hvd_pkg::*; #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cell_load_type      load,
   input  wire cell_ctl_type       ctl,
   input  wire logic [COST_W-1:0]  metric_in,
   input  wire logic [STATE_W-1:0] src_in,
   output logic [COST_W-1:0]       metric_out,
   output logic [STATE_W-1:0]      src_out,
   output logic [COST_W-1:0]       best_out,
   output logic [STATE_W-1:0]      arg_out
);

   localparam logic [STATE_W-1:0] MY_STATE = STATE_W'(CELL_INDEX);

   logic [COST_W-1:0]  trans_ff [NUM_STATES];
   logic [COST_W-1:0]  emis_ff  [NUM_SYMBOLS];
   logic [COST_W-1:0]  init_ff;
   logic [COST_W-1:0]  e_ff;
   logic [COST_W-1:0]  m_ff;
   logic [STATE_W-1:0] src_ff;
   logic [COST_W-1:0]  best_ff;
   logic [STATE_W-1:0] arg_ff;
   logic [COST_W-1:0]  cand_in;
   logic               take_in;

   // The metric held in m_ff belongs to source state src_ff; both travel the ring.
   assign cand_in = sat_add(sat_add(m_ff, trans_ff[src_ff]), e_ff);
   assign take_in = (cand_in < best_ff) || (cand_in == best_ff && src_ff < arg_ff);

   always_ff @(posedge clock) begin
      if (load.trans_we && load.column[STATE_W-1:0] == MY_STATE) begin
         trans_ff[load.row] <= load.cost;
      end
      if (load.emis_we && load.row == MY_STATE) begin
         emis_ff[load.column] <= load.cost;
      end
      if (load.init_we && load.row == MY_STATE) begin
         init_ff <= load.cost;
      end
      if (ctl.load_e) begin
         e_ff    <= emis_ff[ctl.symbol];
         best_ff <= COST_INF;
         arg_ff  <= '0;
      end else if (ctl.init_en) begin
         best_ff <= sat_add(init_ff, e_ff);
      end else if (ctl.acs_en && take_in) begin
         best_ff <= cand_in;
         arg_ff  <= src_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff   <= '0;
         src_ff <= MY_STATE;
      end else if (ctl.acs_en) begin
         m_ff   <= metric_in;
         src_ff <= src_in;
      end else if (ctl.norm_en) begin
         m_ff <= (best_ff == COST_INF) ? COST_INF : best_ff - ctl.min;
      end else if (ctl.clear_en) begin
         m_ff <= '0;
      end
   end

   assign metric_out = m_ff;
   assign src_out    = src_ff;
   assign best_out   = best_ff;
   assign arg_out    = arg_ff;

endmodule

`default_nettype wire

[tb/sv/hmm_viterbi_decoder_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hmm_viterbi_decoder_core: loads the cost tables, runs
// observation sequences, and checks every path entry against a built-in Viterbi predictor.
// Depends on hvd_pkg and the decoder RTL.

module hmm_viterbi_decoder_core_tb;
   import hvd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      op_type             op;
      logic [STATE_W-1:0] row;
      logic [SYM_W-1:0]   column;
      logic [COST_W-1:0]  cost;
      logic [SYM_W-1:0]   symbol;
      logic               last;
   } hmm_item_type;

   typedef struct {
      logic [STATE_W-1:0] path_state;
      logic [POS_W-1:0]   position;
      logic               path_end;
      logic               overflow;
   } path_entry_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_operation;
   logic [STATE_W-1:0] req_row;
   logic [SYM_W-1:0] req_column;
   logic [COST_W-1:0] req_cost;
   logic [SYM_W-1:0] req_symbol;
   logic req_last;
   logic rsp_strobe;
   logic [STATE_W-1:0] rsp_path_state;
   logic [POS_W-1:0] rsp_position;
   logic rsp_path_end;
   logic rsp_overflow;

   hmm_item_type   pending_items[$];
   path_entry_type expected_path[$];
   hmm_item_type   driven_item;
   bit             item_taken;
   bit             failed;
   int             idle_pct;
   int             cycle_count;

   // Predictor state.
   logic [COST_W-1:0]  trans_tab[NUM_STATES][NUM_STATES];
   logic [COST_W-1:0]  emis_tab[NUM_STATES][NUM_SYMBOLS];
   logic [COST_W-1:0]  init_tab[NUM_STATES];
   logic [COST_W-1:0]  metric[NUM_STATES];
   logic [STATE_W-1:0] backptr[MAX_LENGTH][NUM_STATES];
   int                 steps_stored;
   bit                 dropped;

   hmm_viterbi_decoder_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_row(req_row), .req_column(req_column),
      .req_cost(req_cost), .req_symbol(req_symbol), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_path_state(rsp_path_state),
      .rsp_position(rsp_position), .rsp_path_end(rsp_path_end),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [COST_W-1:0] cost_sum(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
      logic [COST_W:0] total;
      total = a + b;
      if (a == COST_INF || b == COST_INF || total >= COST_INF) begin
         return COST_INF;
      end
      return total[COST_W-1:0];
   endfunction

   task automatic predict_viterbi(input hmm_item_type it);
      logic [COST_W-1:0] nxt[NUM_STATES];
      logic [COST_W-1:0] best;
      logic [COST_W-1:0] cand;
      logic [COST_W-1:0] low;
      int arg;
      int path[MAX_LENGTH];
      path_entry_type entry;
      case (it.op)
         OP_LOAD_TRANS: begin
            if (it.column < NUM_STATES) trans_tab[it.row][it.column] = it.cost;
         end
         OP_LOAD_EMIS: begin
            emis_tab[it.row][it.column] = it.cost;
         end
         OP_LOAD_INIT: begin
            init_tab[it.row] = it.cost;
         end
         OP_OBSERVE: begin
            if (steps_stored >= MAX_LENGTH) begin
               dropped = 1'b1;
            end else begin
               for (int j = 0; j < NUM_STATES; j++) begin
                  if (steps_stored == 0) begin
                     nxt[j] = cost_sum(init_tab[j], emis_tab[j][it.symbol]);
                  end else begin
                     best = COST_INF;
                     arg = 0;
                     for (int i = 0; i < NUM_STATES; i++) begin
                        cand = cost_sum(cost_sum(metric[i], trans_tab[i][j]),
                                        emis_tab[j][it.symbol]);
                        if (cand < best) begin
                           best = cand;
                           arg = i;
                        end
                     end
                     nxt[j] = best;
                     backptr[steps_stored][j] = arg[STATE_W-1:0];
                  end
               end
               low = COST_INF;
               foreach (nxt[i]) if (nxt[i] < low) low = nxt[i];
               foreach (nxt[i]) metric[i] = (nxt[i] == COST_INF) ? COST_INF : nxt[i] - low;
               steps_stored++;
            end
            if (it.last) begin
               best = COST_INF;
               arg = 0;
               for (int i = 0; i < NUM_STATES; i++) begin
                  if (metric[i] < best) begin
                     best = metric[i];
                     arg = i;
                  end
               end
               path[steps_stored-1] = arg;
               for (int t = steps_stored - 2; t >= 0; t--) path[t] = backptr[t+1][path[t+1]];
               for (int k = 0; k < steps_stored; k++) begin
                  entry.path_state = STATE_W'(path[k]);
                  entry.position = POS_W'(k);
                  entry.path_end = (k == steps_stored - 1);
                  entry.overflow = dropped;
                  expected_path.push_back(entry);
               end
               steps_stored = 0;
               dropped = 1'b0;
               foreach (metric[i]) metric[i] = '0;
            end
         end
      endcase
   endtask

   // Driver: a new item is presented at the falling edge once the previous one was taken.
   always @(negedge clock) begin
      hmm_item_type nxt_item;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         item_taken = 1'b0;
         if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            nxt_item = pending_items.pop_front();
            driven_item = nxt_item;
            start <= 1'b1;
            req_operation <= nxt_item.op;
            req_row <= nxt_item.row;
            req_column <= nxt_item.column;
            req_cost <= nxt_item.cost;
            req_symbol <= nxt_item.symbol;
            req_last <= nxt_item.last;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predicts on acceptance and checks every strobed path entry.
   always @(posedge clock) begin
      path_entry_type want;
      if (!reset) begin
         if (start && !busy) begin
            predict_viterbi(driven_item);
            item_taken = 1'b1;
         end
         if (rsp_strobe) begin
            if (expected_path.size() == 0) begin
               $error("unexpected path entry: position %0d state %0d",
                      rsp_position, rsp_path_state);
               failed = 1'b1;
            end else begin
               want = expected_path.pop_front();
               if (rsp_path_state !== want.path_state) begin
                  $error("path_state: expected %0d, got %0d", want.path_state, rsp_path_state);
                  failed = 1'b1;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
                  failed = 1'b1;
               end
               if (rsp_path_end !== want.path_end) begin
                  $error("path_end: expected %0d, got %0d", want.path_end, rsp_path_end);
                  failed = 1'b1;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_overflow);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hmm_viterbi_decoder_core_tb NOT OK");
         $finish;
      end
   end

   function automatic logic [COST_W-1:0] pick_cost();
      case ($urandom_range(7))
         0: return '0;
         1: return COST_INF;
         2: return COST_W'($urandom);
         default: return COST_W'($urandom_range(400));
      endcase
   endfunction

   task automatic add_load(input op_type op, input int row, input int column,
                           input logic [COST_W-1:0] cost, input bit last);
      hmm_item_type it;
      it.op = op;
      it.row = STATE_W'(row);
      it.column = SYM_W'(column);
      it.cost = cost;
      it.symbol = SYM_W'($urandom);
      it.last = last;
      pending_items.push_back(it);
   endtask

   task automatic add_sequence(input int len);
      hmm_item_type it;
      for (int k = 0; k < len; k++) begin
         it.op = OP_OBSERVE;
         it.row = STATE_W'($urandom);
         it.column = SYM_W'($urandom);
         it.cost = COST_W'($urandom);
         it.symbol = SYM_W'($urandom);
         it.last = (k == len - 1);
         pending_items.push_back(it);
      end
   endtask

   task automatic fill_tables();
      for (int r = 0; r < NUM_STATES; r++) begin
         add_load(OP_LOAD_INIT, r, $urandom, pick_cost(), 1'b0);
         for (int c = 0; c < NUM_STATES; c++)
            add_load(OP_LOAD_TRANS, r, c, pick_cost(), $urandom_range(1));
         for (int c = 0; c < NUM_SYMBOLS; c++)
            add_load(OP_LOAD_EMIS, r, c, pick_cost(), 1'b0);
      end
   endtask

   // Waits until every queued item was taken and every path entry has come out.
   task automatic drain();
      wait (pending_items.size() == 0 && !start && expected_path.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int budget;
      int len;
      reset = 1'b1;
      start = 1'b0;
      req_operation = '0;
      req_row = '0;
      req_column = '0;
      req_cost = '0;
      req_symbol = '0;
      req_last = 1'b0;
      idle_pct = 0;
      steps_stored = 0;
      dropped = 1'b0;
      foreach (metric[i]) metric[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: every table filled, then short, full-length and overlong runs.
      fill_tables();
      add_load(OP_LOAD_TRANS, 7, 15, 16'h1234, 1'b1);   // column past the table: ignored
      add_load(OP_LOAD_TRANS, 0, 8, '0, 1'b0);
      add_sequence(1);
      add_sequence(2);
      add_sequence(MAX_LENGTH);
      add_sequence(MAX_LENGTH + 3);
      // Every initial cost infinite: all metrics infinite, state 0 wins throughout.
      for (int r = 0; r < NUM_STATES; r++) add_load(OP_LOAD_INIT, r, 0, COST_INF, 1'b0);
      add_sequence(3);
      // All-zero initial costs can make ties between states.
      for (int r = 0; r < NUM_STATES; r++) add_load(OP_LOAD_INIT, r, 0, '0, 1'b0);
      add_sequence(4);
      drain();

      // Random part in three phases of sender idling; the budget counts items.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 0 : (phase == 1) ? 88 : 10;
         budget = 20;
         while (budget > 0) begin
            if ($urandom_range(99) < 30) begin
               add_load(op_type'($urandom_range(2)), $urandom, $urandom, pick_cost(),
                        $urandom_range(1));
               budget--;
            end else begin
               len = $urandom_range(1, 8);
               add_sequence(len);
               budget -= len;
            end
         end
         drain();
      end

      if (!failed && expected_path.size() == 0) begin
         $display("hmm_viterbi_decoder_core_tb OK");
      end else begin
         $display("hmm_viterbi_decoder_core_tb NOT OK");
      end
      $finish;
   end

endmodule
